FILE: rtl/kps_pkg.sv
// ----------------------------------------------------------------------------
// Keep-alive supervisor package
// Widths, reset values, operation and reason codes, and the countdown control
// word that is shared between the top level and the countdown units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

  localparam int unsigned CNT_W     = 26;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CNT_W-1:0] kps_cnt_t;

  localparam kps_cnt_t KEEPALIVE_RST    = '0;
  localparam kps_cnt_t RESP_TIMEOUT_RST = kps_cnt_t'(2000);

  typedef enum logic [2:0] {
    OP_START      = 3'd0,
    OP_TICK       = 3'd1,
    OP_PKT_SENT   = 3'd2,
    OP_PING_RESP  = 3'd3,
    OP_PKT_RCVD   = 3'd4,
    OP_DISCONNECT = 3'd5
  } kps_op_e;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_KA_TIMEOUT = 2'd1,
    REASON_MALFORMED = 2'd2
  } kps_reason_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEEPALIVE    = 1'b0,
    REG_RESP_TIMEOUT = 1'b1
  } kps_reg_e;

  // Load wins over clear, and clear over tick.
  typedef struct packed {
    logic load;
    logic clear;
    logic tick;
  } kps_cnt_ctrl_t;

endpackage : kps_pkg

`default_nettype wire

FILE: rtl/kps_if.sv
// ----------------------------------------------------------------------------
// Keep-alive supervisor channel interfaces
// Event, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kps_event_if;
  logic            valid;
  logic            ready;
  kps_pkg::kps_op_e operation;
  logic            disconnect_malformed;

  modport source (output valid, output operation, output disconnect_malformed,
                  input ready);
  modport sink   (input valid, input operation, input disconnect_malformed,
                  output ready);
endinterface : kps_event_if

interface kps_result_if;
  logic                 valid;
  logic                 ready;
  logic                 send_ping;
  logic                 send_disconnect;
  kps_pkg::kps_reason_e disconnect_reason;
  logic                 link_down;

  modport source (output valid, output send_ping, output send_disconnect,
                  output disconnect_reason, output link_down, input ready);
  modport sink   (input valid, input send_ping, input send_disconnect,
                  input disconnect_reason, input link_down, output ready);
endinterface : kps_result_if

interface kps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [kps_pkg::CFG_IDX_W-1:0]      index;
  kps_pkg::kps_cnt_t                  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : kps_cfg_if

`default_nettype wire

FILE: rtl/kps_countdown.sv
// ----------------------------------------------------------------------------
// Keep-alive supervisor one-shot countdown
// Holds ticks left and an armed flag; flags expiry on the tick that ends it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kps_countdown (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  kps_pkg::kps_cnt_ctrl_t ctrl_i,
  input  kps_pkg::kps_cnt_t      load_val_i,
  output logic                   expiring_o,
  output logic                   armed_o
);
  import kps_pkg::*;

  kps_cnt_t left_q, left_d;
  logic     armed_q, armed_d;

  // A countdown holding one or zero ends on the next tick.
  assign expiring_o = armed_q && (left_q <= kps_cnt_t'(1));
  assign armed_o    = armed_q;

  always_comb begin
    left_d  = left_q;
    armed_d = armed_q;
    if (ctrl_i.load) begin
      left_d  = load_val_i;
      armed_d = 1'b1;
    end else if (ctrl_i.clear) begin
      left_d  = '0;
      armed_d = 1'b0;
    end else if (ctrl_i.tick && armed_q) begin
      if (expiring_o) begin
        left_d  = '0;
        armed_d = 1'b0;
      end else begin
        left_d  = left_q - kps_cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      armed_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      armed_q <= armed_d;
    end
  end

endmodule : kps_countdown

`default_nettype wire

FILE: rtl/keepalive_ping_supervisor_top.sv
// ----------------------------------------------------------------------------
// Keep-alive ping supervisor, top level
// Throughput: one event word per cycle, sustained while results are taken.
// An accepted event word passes through one input register and one result
// register, and the countdowns are updated as the word moves between them.
// Reset: countdowns stopped, session open, keep-alive 0, response timeout
// 2000 ms; the block takes words from the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keepalive_ping_supervisor_top (
  input  wire          clk_i,
  input  wire          rst_ni,
  kps_cfg_if.sink      cfg_i,
  kps_event_if.sink    evt_i,
  kps_result_if.source res_o
);
  import kps_pkg::*;

  // Configuration registers. Writes are always taken; an index outside the
  // register list would simply be ignored, though every code is used here.
  kps_cnt_t keepalive_q;
  kps_cnt_t resp_timeout_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keepalive_q    <= KEEPALIVE_RST;
      resp_timeout_q <= RESP_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      case (kps_reg_e'(cfg_i.index))
        REG_KEEPALIVE:    keepalive_q    <= cfg_i.data;
        REG_RESP_TIMEOUT: resp_timeout_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register stage. The stage drains whenever the result register is
  // empty or is being emptied, so a new word can enter in every cycle.
  logic    in_valid_q;
  kps_op_e in_op_q;
  logic    in_mal_q;
  logic    res_valid_q;
  logic    advance;

  assign advance     = in_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      in_op_q  <= evt_i.operation;
      in_mal_q <= evt_i.disconnect_malformed;
    end
  end

  // The three countdowns: send-idle, receive-idle and response wait.
  kps_cnt_ctrl_t send_ctrl, recv_ctrl, resp_ctrl;
  logic          send_exp, recv_exp, resp_exp;
  logic          send_armed, recv_armed, resp_armed;

  kps_countdown u_send_idle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (send_ctrl),
    .load_val_i (keepalive_q),
    .expiring_o (send_exp),
    .armed_o    (send_armed)
  );

  kps_countdown u_recv_idle (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (recv_ctrl),
    .load_val_i (keepalive_q),
    .expiring_o (recv_exp),
    .armed_o    (recv_armed)
  );

  kps_countdown u_response (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (resp_ctrl),
    .load_val_i (resp_timeout_q),
    .expiring_o (resp_exp),
    .armed_o    (resp_armed)
  );

  // Event decode. Nothing moves unless the input stage advances. A keep-alive
  // of zero makes every idle restart a no-op, leaving a running one alone.
  logic        closed_q, closed_d;
  logic        ka_on;
  logic        ping_d, disc_d, down_d;
  kps_reason_e reason_d;

  assign ka_on = (keepalive_q != '0);

  always_comb begin
    send_ctrl = '0;
    recv_ctrl = '0;
    resp_ctrl = '0;
    closed_d  = closed_q;
    ping_d    = 1'b0;
    disc_d    = 1'b0;
    down_d    = 1'b0;
    reason_d  = REASON_NONE;
    if (advance) begin
      if (in_op_q == OP_START) begin
        // Start reopens the session and arms only the send-idle countdown.
        closed_d        = 1'b0;
        send_ctrl.clear = 1'b1;
        send_ctrl.load  = ka_on;
        recv_ctrl.clear = 1'b1;
        resp_ctrl.clear = 1'b1;
      end else if (!closed_q) begin
        case (in_op_q)
          OP_TICK: begin
            if (resp_exp) begin
              // A response expiry beats any idle expiry in the same tick.
              send_ctrl.clear = 1'b1;
              recv_ctrl.clear = 1'b1;
              resp_ctrl.clear = 1'b1;
              closed_d        = 1'b1;
              disc_d          = 1'b1;
              reason_d        = REASON_KA_TIMEOUT;
              down_d          = 1'b1;
            end else begin
              ping_d         = (send_exp || recv_exp) && !resp_armed;
              resp_ctrl.tick = 1'b1;
              resp_ctrl.load = ping_d;
              recv_ctrl.tick = 1'b1;
              send_ctrl.tick = 1'b1;
              // The ping itself counts as a sent packet.
              send_ctrl.load = ping_d && ka_on;
            end
          end
          OP_PKT_SENT: begin
            send_ctrl.load = ka_on;
          end
          OP_PING_RESP: begin
            resp_ctrl.clear = 1'b1;
            recv_ctrl.load  = ka_on;
          end
          OP_PKT_RCVD: begin
            recv_ctrl.load = ka_on;
          end
          OP_DISCONNECT: begin
            send_ctrl.clear = 1'b1;
            recv_ctrl.clear = 1'b1;
            resp_ctrl.clear = 1'b1;
            closed_d        = 1'b1;
            down_d          = 1'b1;
            if (in_mal_q) begin
              disc_d   = 1'b1;
              reason_d = REASON_MALFORMED;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      closed_q <= closed_d;
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result register; it is loaded only when the previous word has gone.
  logic        res_ping_q, res_disc_q, res_down_q;
  kps_reason_e res_reason_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_ping_q   <= ping_d;
      res_disc_q   <= disc_d;
      res_reason_q <= reason_d;
      res_down_q   <= down_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.send_ping         = res_ping_q;
  assign res_o.send_disconnect   = res_disc_q;
  assign res_o.disconnect_reason = res_reason_q;
  assign res_o.link_down         = res_down_q;

  // The armed flags of the idle countdowns only steer their own expiry.
  logic unused_armed;
  assign unused_armed = send_armed ^ recv_armed;

endmodule : keepalive_ping_supervisor_top

`default_nettype wire

FILE: rtl/kps_checker.sv
// ----------------------------------------------------------------------------
// Keep-alive supervisor port checker
// Checks result words against the rules of the supervisor as seen on ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kps_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       res_valid_i,
  input wire       res_ready_i,
  input wire       send_ping_i,
  input wire       send_disc_i,
  input wire [1:0] reason_i,
  input wire       link_down_i
);
  import kps_pkg::*;

  // A reason is only given with a disconnect.
  a_reason_needs_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !send_disc_i |-> reason_i == REASON_NONE)
    else $error("disconnect reason without disconnect");

  // A ping never comes with a dropped link.
  a_ping_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && send_ping_i |-> !send_disc_i && !link_down_i)
    else $error("ping together with disconnect or link down");

  // Every disconnect that is sent also drops the link.
  a_disc_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && send_disc_i |-> link_down_i)
    else $error("disconnect sent while link kept up");

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable({send_ping_i, send_disc_i, reason_i, link_down_i}))
    else $error("stalled result word changed");

endmodule : kps_checker

bind keepalive_ping_supervisor_top kps_checker u_kps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .send_ping_i (res_o.send_ping),
  .send_disc_i (res_o.send_disconnect),
  .reason_i    (res_o.disconnect_reason),
  .link_down_i (res_o.link_down)
);

`default_nettype wire

FILE: tb/tb_keepalive_ping_supervisor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keep-alive ping supervisor testbench
// Drives event words into the supervisor, keeps a cycle-free model of its three
// countdowns and its session flag, and compares every result word, field by
// field, with the outcome that the model predicts for the accepted event.
// ----------------------------------------------------------------------------

module tb_keepalive_ping_supervisor_top;
  import kps_pkg::*;

  // One event word as the sender holds it before it goes on the channel.
  typedef struct packed {
    kps_op_e op;
    logic    malformed;
  } evt_word_t;

  // The result word that an event is expected to produce.
  typedef struct packed {
    logic        ping;
    logic        disc;
    kps_reason_e reason;
    logic        down;
  } outcome_t;

  localparam int unsigned BATCH_WORDS = 150;
  localparam int unsigned ITEM_TARGET = 1200;
  localparam int unsigned N_SETTINGS  = 10;

  // Register settings visited by the random phases, in turn. They cover a
  // disabled keep-alive, zero and one as response timeouts, tiny periods that
  // make pings frequent, the documented maximum and every register bit set.
  kps_cnt_t keepalive_plan [N_SETTINGS] = '{
    kps_cnt_t'(0), kps_cnt_t'(5), kps_cnt_t'(1), kps_cnt_t'(3), '1,
    kps_cnt_t'(65535000), kps_cnt_t'(8), kps_cnt_t'(1), kps_cnt_t'(4), kps_cnt_t'(0)
  };
  kps_cnt_t resp_plan [N_SETTINGS] = '{
    kps_cnt_t'(1), kps_cnt_t'(3), kps_cnt_t'(1), kps_cnt_t'(0), '1,
    kps_cnt_t'(65535000), kps_cnt_t'(12), kps_cnt_t'(0), kps_cnt_t'(2), kps_cnt_t'(2000)
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  kps_cfg_if    cfg_if ();
  kps_event_if  evt_if ();
  kps_result_if res_if ();

  // The event channel and the result ready are driven from registers that
  // hold known values from time zero, so the block never sees an unknown.
  logic    evt_valid = 1'b0;
  kps_op_e evt_op    = OP_START;
  logic    evt_mal   = 1'b0;
  logic    res_ready = 1'b0;

  assign evt_if.valid                = evt_valid;
  assign evt_if.operation            = evt_op;
  assign evt_if.disconnect_malformed = evt_mal;
  assign res_if.ready                = res_ready;

  keepalive_ping_supervisor_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Pending event words, filled by the stimulus process and drained by the
  // driver, and the outcomes still owed by the block, oldest first.
  evt_word_t   event_q[$];
  outcome_t    outcome_q[$];
  int unsigned queued_cnt   = 0;
  int unsigned taken_cnt    = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt      = 0;

  // Idling switches, flipped between phases so that some stretches run at
  // full rate on one side or both.
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;

  // ---------------------------------------------------------------------------
  // Supervisor model: its own copy of the registers and of the countdowns.
  // ---------------------------------------------------------------------------
  kps_cnt_t keepalive_period = KEEPALIVE_RST;
  kps_cnt_t response_limit   = RESP_TIMEOUT_RST;
  kps_cnt_t send_left = '0;
  kps_cnt_t recv_left = '0;
  kps_cnt_t resp_left = '0;
  logic     send_on   = 1'b0;
  logic     recv_on   = 1'b0;
  logic     resp_on   = 1'b0;
  logic     closed    = 1'b0;

  // A keep-alive of zero leaves an idle countdown exactly as it was, running
  // or not; it never stops one.
  function automatic void arm_send_idle();
    if (keepalive_period != '0) begin
      send_left = keepalive_period;
      send_on   = 1'b1;
    end
  endfunction

  function automatic void arm_recv_idle();
    if (keepalive_period != '0) begin
      recv_left = keepalive_period;
      recv_on   = 1'b1;
    end
  endfunction

  function automatic void stop_timers();
    send_on   = 1'b0;
    recv_on   = 1'b0;
    resp_on   = 1'b0;
    send_left = '0;
    recv_left = '0;
    resp_left = '0;
  endfunction

  // One millisecond on a countdown. A count of zero or one expires now.
  function automatic logic tick_down(ref kps_cnt_t left, ref logic on);
    if (!on) begin
      return 1'b0;
    end
    if (left <= kps_cnt_t'(1)) begin
      left = '0;
      on   = 1'b0;
      return 1'b1;
    end
    left = left - kps_cnt_t'(1);
    return 1'b0;
  endfunction

  // Applies one accepted event to the model and files the outcome it owes.
  function automatic void advance_supervisor(kps_op_e op, logic malformed);
    outcome_t o;
    logic     resp_exp;
    logic     send_exp;
    logic     recv_exp;
    o = '0;
    if (op == OP_START) begin
      closed = 1'b0;
      stop_timers();
      arm_send_idle();
    end else if (!closed) begin
      case (op)
        OP_TICK: begin
          resp_exp = tick_down(resp_left, resp_on);
          send_exp = tick_down(send_left, send_on);
          recv_exp = tick_down(recv_left, recv_on);
          if (resp_exp) begin
            // The response wait ran out: this wins over any idle expiry.
            stop_timers();
            closed   = 1'b1;
            o.disc   = 1'b1;
            o.reason = REASON_KA_TIMEOUT;
            o.down   = 1'b1;
          end else if ((send_exp || recv_exp) && !resp_on) begin
            // The ping itself counts as a sent packet.
            o.ping    = 1'b1;
            resp_left = response_limit;
            resp_on   = 1'b1;
            arm_send_idle();
          end
        end
        OP_PKT_SENT: begin
          arm_send_idle();
        end
        OP_PING_RESP: begin
          resp_on   = 1'b0;
          resp_left = '0;
          arm_recv_idle();
        end
        OP_PKT_RCVD: begin
          arm_recv_idle();
        end
        OP_DISCONNECT: begin
          stop_timers();
          closed = 1'b1;
          o.down = 1'b1;
          if (malformed) begin
            o.disc   = 1'b1;
            o.reason = REASON_MALFORMED;
          end
        end
        default: begin
        end
      endcase
    end
    outcome_q.push_back(o);
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver. A word leaves the queue only once the previous one has been
  // taken, after a random gap that is mostly nothing, sometimes short and now
  // and then a long pause.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  function automatic int unsigned send_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_idle_en || r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin : event_driver
    evt_word_t nxt;
    logic      taken;
    if (rst_ni) begin
      taken = evt_valid && evt_if.ready;
      if (taken) begin
        advance_supervisor(evt_op, evt_mal);
        taken_cnt++;
      end
      if (!evt_valid || taken) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          evt_valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          nxt = event_q.pop_front();
          evt_valid <= 1'b1;
          evt_op    <= nxt.op;
          evt_mal   <= nxt.malformed;
          gap_left  <= send_gap();
        end else begin
          evt_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready. Short random stalls, a rare long one, and once in the run a
  // much longer hold while the driver keeps offering, so that the block backs
  // up and has to refuse event words.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk_i) begin : result_ready_gen
    int unsigned r;
    if (rst_ni) begin
      r = $urandom_range(0, 99);
      if (!long_hold_done && results_seen >= 250) begin
        long_hold_done <= 1'b1;
        stall_left     <= 300;
        res_ready      <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        res_ready  <= 1'b0;
      end else if (!rx_idle_en || r < 75) begin
        res_ready <= 1'b1;
      end else begin
        res_ready  <= 1'b0;
        stall_left <= (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker. Every word taken is matched against the oldest outcome.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    outcome_t want;
    if (rst_ni && res_if.valid && res_ready) begin
      results_seen <= results_seen + 1;
      if (outcome_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result word with nothing expected, got ping=%0d disc=%0d reason=%0d down=%0d",
                 $time, res_if.send_ping, res_if.send_disconnect,
                 res_if.disconnect_reason, res_if.link_down);
      end else begin
        want = outcome_q.pop_front();
        check_field("send_ping", want.ping, res_if.send_ping);
        check_field("send_disconnect", want.disc, res_if.send_disconnect);
        check_field("disconnect_reason", want.reason, res_if.disconnect_reason);
        check_field("link_down", want.down, res_if.link_down);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_event(kps_op_e op, logic malformed);
    evt_word_t w;
    w.op        = op;
    w.malformed = malformed;
    event_q.push_back(w);
    queued_cnt++;
  endtask

  // A mix shaped like real traffic: mostly millisecond ticks, with packets
  // both ways, ping responses, session starts to reopen a dropped link, the
  // odd disconnect and a few undefined operation codes.
  task automatic push_random_event();
    int unsigned r;
    logic        mal;
    r   = $urandom_range(0, 99);
    mal = 1'($urandom_range(0, 1));
    if (r < 55) begin
      push_event(OP_TICK, mal);
    end else if (r < 65) begin
      push_event(OP_PKT_SENT, mal);
    end else if (r < 75) begin
      push_event(OP_PKT_RCVD, mal);
    end else if (r < 84) begin
      push_event(OP_PING_RESP, mal);
    end else if (r < 91) begin
      push_event(OP_START, mal);
    end else if (r < 96) begin
      push_event(OP_DISCONNECT, mal);
    end else begin
      push_event(kps_op_e'($urandom_range(6, 7)), mal);
    end
  endtask

  // The sender holds off until every word queued so far has been taken and
  // every outcome has come back.
  task automatic wait_quiet();
    while (taken_cnt != queued_cnt || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(kps_reg_e idx, kps_cnt_t value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_KEEPALIVE) begin
      keepalive_period = value;
    end else begin
      response_limit = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_KEEPALIVE;
    cfg_if.data  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset settings the keep-alive is off: a tick with nothing
    // running and a start that arms nothing.
    push_event(OP_TICK, 1'b0);
    push_event(OP_START, 1'b0);
    push_event(OP_PKT_SENT, 1'b1);
    wait_quiet();

    // Short periods so that each expiry falls within a few ticks.
    write_reg(REG_KEEPALIVE, kps_cnt_t'(2));
    write_reg(REG_RESP_TIMEOUT, kps_cnt_t'(3));

    // Send-idle expiry requests a ping; the send-idle countdown then runs out
    // again while the response is awaited and quietly stops; the response
    // wait expires and the link is dropped.
    push_event(OP_START, 1'b0);
    push_event(OP_TICK, 1'b0);
    push_event(OP_TICK, 1'b0);
    push_event(OP_TICK, 1'b0);
    push_event(OP_TICK, 1'b0);
    push_event(OP_TICK, 1'b0);
    // A closed session ignores everything but a start.
    push_event(OP_TICK, 1'b0);
    push_event(OP_PKT_RCVD, 1'b0);
    push_event(OP_DISCONNECT, 1'b1);
    // A ping response with none awaited only restarts receive-idle; then both
    // idle countdowns expire on the same tick and ask for a single ping.
    push_event(OP_START, 1'b0);
    push_event(OP_PKT_RCVD, 1'b0);
    push_event(OP_PING_RESP, 1'b0);
    push_event(OP_TICK, 1'b1);
    push_event(OP_TICK, 1'b0);
    push_event(OP_PING_RESP, 1'b0);
    // Undefined codes, and the malformed flag on a packet that is not a
    // disconnect, change nothing.
    push_event(kps_op_e'(3'd6), 1'b0);
    push_event(kps_op_e'(3'd7), 1'b1);
    push_event(OP_PKT_SENT, 1'b1);
    // A clean disconnect, then a malformed one after a restart.
    push_event(OP_DISCONNECT, 1'b0);
    push_event(OP_START, 1'b0);
    push_event(OP_DISCONNECT, 1'b1);
    wait_quiet();

    // Random phases, each under its own pair of register settings. The model
    // state is carried over, so a phase may begin with countdowns left running
    // under the previous keep-alive period.
    phase = 0;
    while (queued_cnt < ITEM_TARGET) begin
      k = phase % N_SETTINGS;
      write_reg(REG_KEEPALIVE, keepalive_plan[k]);
      write_reg(REG_RESP_TIMEOUT, resp_plan[k]);
      tx_idle_en <= (phase % 3 != 1);
      rx_idle_en <= (phase % 4 != 2);
      repeat (BATCH_WORDS) push_random_event();
      wait_quiet();
      phase++;
    end

    if (err_cnt == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule : tb_keepalive_ping_supervisor_top
